// ===== rtl/kbp_pkg.sv =====
// kbp_pkg: types, constants and hash step functions for the k-mer Bloom prefilter.
// No dependencies; used by every rtl file through scoped names.
`default_nettype none
package kbp_pkg;

	localparam int WORD_BITS     = 62;
	localparam int QDEPTH        = 4;
	localparam int QPTR_BITS     = 2;
	localparam int NUM_OPS       = 6;
	localparam int HASH_STEPS    = 8;
	localparam int ROW_LSB       = 6;
	localparam int APB_ADDR_BITS = 4;
	localparam int MAX_K         = 30;
	localparam logic [7:0] QUAL_OFFSET = 8'd33;

	typedef enum logic [1:0] {
		REG_KMER_LENGTH     = 2'd0,
		REG_MIN_QUALITY     = 2'd1,
		REG_DEFAULT_QUALITY = 2'd2,
		REG_BLOOM_LOG2      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] base_char;
		logic [7:0] qual_char;
		logic       quality_present;
		logic       first_of_read;
	} item_t;

	typedef struct packed {
		logic                 inserted;
		logic [WORD_BITS-1:0] forward_word;
		logic                 forward_repeat;
		logic [WORD_BITS-1:0] reverse_word;
		logic                 reverse_repeat;
	} result_t;

	typedef struct packed {
		logic [4:0]  k;
		logic [63:0] wmask;
		logic [63:0] amask;
		logic [7:0]  min_q;
		logic [7:0]  def_q;
	} cfg_t;

	typedef struct packed {
		logic                 ins;
		logic [WORD_BITS-1:0] fwd;
		logic [WORD_BITS-1:0] rev;
	} entry_t;

	typedef struct packed {
		logic [63:0] v;
		logic [63:0] t;
	} vt_t;

	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		vt_t         c;
	} hash_t;

	function automatic logic [63:0] a_line(input logic [63:0] v, input logic [2:0] i,
			input logic [63:0] m);
		logic [63:0] r;
		case (i)
			3'd0: r = (v + ~(v << 32)) & m;
			3'd1: r = (v ^ (v >> 22)) & m;
			3'd2: r = (v + (v << 13)) & m;
			3'd3: r = (v ^ (v >> 24)) & m;
			3'd4: r = (v + ~(v << 27)) & m;
			3'd5: r = (v ^ (v >> 31)) & m;
			default: r = v;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] b_line(input logic [63:0] v, input logic [2:0] i);
		logic [63:0] r;
		case (i)
			3'd0: r = (~v) + (v << 21);
			3'd1: r = v ^ (v >> 24);
			3'd2: r = (v + (v << 3)) + (v << 8);
			3'd3: r = v ^ (v >> 14);
			3'd4: r = (v + (v << 2)) + (v << 4);
			3'd5: r = v ^ (v >> 28);
			3'd6: r = v + (v << 31);
			default: r = v;
		endcase
		return r;
	endfunction

	function automatic vt_t c_line(input vt_t x, input logic [3:0] i, input logic [63:0] m);
		vt_t r;
		r = x;
		case (i)
			4'd0:  r.t = (x.v ^ (x.v >> 31)) & m;
			4'd1:  r.v = (x.v ^ (x.t >> 31)) & m;
			4'd2:  r.t = (x.v - (~x.v << 27)) & m;
			4'd3:  r.v = (x.v - (~x.t << 27) + 64'd1) & m;
			4'd4:  r.t = (x.v ^ (x.v >> 24)) & m;
			4'd5:  r.v = (x.v ^ (x.t >> 24)) & m;
			4'd6:  r.t = (x.v - (x.v << 13)) & m;
			4'd7:  r.t = (x.v - (x.t << 13)) & m;
			4'd8:  r.t = (x.v - (x.t << 13)) & m;
			4'd9:  r.v = (x.v - (x.t << 13)) & m;
			4'd10: r.t = (x.v ^ (x.v >> 22)) & m;
			4'd11: r.t = (x.v ^ (x.t >> 22)) & m;
			4'd12: r.v = (x.v ^ (x.t >> 22)) & m;
			4'd13: r.t = (x.v - (~x.v << 32)) & m;
			4'd14: r.v = (x.v - (~x.t << 32) + 64'd1) & m;
			default: r = x;
		endcase
		return r;
	endfunction

	function automatic hash_t hash_init(input logic [WORD_BITS-1:0] w);
		hash_t r;
		r.a   = {2'b00, w};
		r.b   = {2'b00, w};
		r.c.v = {2'b00, w};
		r.c.t = 64'd0;
		return r;
	endfunction

	// one line of each of the first two mixes and two lines of the third per step
	function automatic hash_t hash_step(input hash_t h, input logic [2:0] s,
			input logic [63:0] m);
		hash_t r;
		r.a = a_line(h.a, s, m);
		r.b = b_line(h.b, s);
		r.c = c_line(c_line(h.c, {s, 1'b0}, m), {s, 1'b1}, m);
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/kbp_front.sv =====
// kbp_front: decodes base and quality, rolls forward and reverse words, decides insertion.
// Depends on kbp_pkg.
`default_nettype none
module kbp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_stall,
	input  wire kbp_pkg::item_t item,
	input  wire kbp_pkg::cfg_t  cfg,
	input  wire logic           hold,
	output logic                push,
	output kbp_pkg::entry_t     entry
);

	logic [kbp_pkg::WORD_BITS-1:0] fwd_q, rev_q;
	logic [4:0]                    run_q;
	logic [63:0]                   fw0, rv0, fwd_n, rev_n;
	logic [4:0]                    run0, run_n;
	logic [5:0]                    run_inc, kp1;
	logic [1:0]                    code;
	logic                          is_base;
	logic [7:0]                    qual;
	logic                          ins;

	assign item_stall = hold;
	assign push       = item_valid && !hold;

	always_comb begin
		code    = 2'd0;
		is_base = 1'b1;
		case (item.base_char) inside
			"A", "a": code = 2'd0;
			"C", "c": code = 2'd1;
			"G", "g": code = 2'd2;
			"T", "t": code = 2'd3;
			default:  is_base = 1'b0;
		endcase
	end

	always_comb begin
		fw0     = item.first_of_read ? 64'd0 : {2'b00, fwd_q};
		rv0     = item.first_of_read ? 64'd0 : {2'b00, rev_q};
		run0    = item.first_of_read ? 5'd0 : run_q;
		qual    = item.quality_present ? (item.qual_char - kbp_pkg::QUAL_OFFSET) : cfg.def_q;
		kp1     = {1'b0, cfg.k} + 6'd1;
		run_inc = {1'b0, run0} + 6'd1;
		fwd_n   = fw0;
		rev_n   = rv0;
		run_n   = 5'd0;
		ins     = 1'b0;
		if (is_base) begin
			fwd_n = ((fw0 << 2) | {62'd0, code}) & cfg.wmask;
			rev_n = (((rv0 & cfg.wmask) >> 2) | ({62'd0, ~code} << {cfg.k, 1'b0}))
				& cfg.wmask;
			run_n = (run_inc > kp1) ? kp1[4:0] : run_inc[4:0];
			ins   = ({1'b0, run_n} >= kp1) && (qual >= cfg.min_q);
		end
	end

	assign entry.ins = ins;
	assign entry.fwd = fwd_n[kbp_pkg::WORD_BITS-1:0];
	assign entry.rev = rev_n[kbp_pkg::WORD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= '0;
			rev_q <= '0;
			run_q <= '0;
		end else if (push) begin
			fwd_q <= fwd_n[kbp_pkg::WORD_BITS-1:0];
			rev_q <= rev_n[kbp_pkg::WORD_BITS-1:0];
			run_q <= run_n;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kbp_queue.sv =====
// kbp_queue: short queue of classified words between front and back.
// Depends on kbp_pkg.
`default_nettype none
module kbp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire kbp_pkg::entry_t din,
	output logic                 full,
	input  wire logic            pop,
	output kbp_pkg::entry_t      dout,
	output logic                 empty
);

	kbp_pkg::entry_t               slot_q [kbp_pkg::QDEPTH];
	logic [kbp_pkg::QPTR_BITS:0]   wp_q, rp_q;

	assign empty = (wp_q == rp_q);
	assign full  = (wp_q[kbp_pkg::QPTR_BITS-1:0] == rp_q[kbp_pkg::QPTR_BITS-1:0])
		&& (wp_q[kbp_pkg::QPTR_BITS] != rp_q[kbp_pkg::QPTR_BITS]);
	assign dout  = slot_q[rp_q[kbp_pkg::QPTR_BITS-1:0]];

	always_ff @(posedge clk) begin
		if (push && !full)
			slot_q[wp_q[kbp_pkg::QPTR_BITS-1:0]] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push && !full)
				wp_q <= wp_q + 1'b1;
			if (pop && !empty)
				rp_q <= rp_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kbp_hash.sv =====
// kbp_hash: iterative three-way hash of the forward and reverse word, eight steps.
// Depends on kbp_pkg.
`default_nettype none
module kbp_hash #(
	parameter int ADDR_BITS = 23
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire kbp_pkg::entry_t       ld_entry,
	input  wire kbp_pkg::cfg_t         cfg,
	output logic                       ready,
	output logic                       done,
	input  wire logic                  take,
	output kbp_pkg::entry_t            entry,
	output logic [kbp_pkg::NUM_OPS-1:0][ADDR_BITS-1:0] idx
);

	logic            busy_q, done_q;
	logic [2:0]      step_q;
	kbp_pkg::entry_t ent_q;
	kbp_pkg::hash_t  hf_q, hr_q;
	logic [ADDR_BITS-1:0] am;

	assign ready = !busy_q && !done_q;
	assign done  = done_q;
	assign entry = ent_q;
	assign am    = cfg.amask[ADDR_BITS-1:0];

	// forward word first, then reverse
	assign idx[0] = hf_q.a[ADDR_BITS-1:0] & am;
	assign idx[1] = hf_q.b[ADDR_BITS-1:0] & am;
	assign idx[2] = hf_q.c.v[ADDR_BITS-1:0] & am;
	assign idx[3] = hr_q.a[ADDR_BITS-1:0] & am;
	assign idx[4] = hr_q.b[ADDR_BITS-1:0] & am;
	assign idx[5] = hr_q.c.v[ADDR_BITS-1:0] & am;

	always_ff @(posedge clk) begin
		if (load && ready) begin
			ent_q <= ld_entry;
			hf_q  <= kbp_pkg::hash_init(ld_entry.fwd);
			hr_q  <= kbp_pkg::hash_init(ld_entry.rev);
		end else if (busy_q) begin
			hf_q <= kbp_pkg::hash_step(hf_q, step_q, cfg.wmask);
			hr_q <= kbp_pkg::hash_step(hr_q, step_q, cfg.wmask);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (load && ready) begin
				busy_q <= ld_entry.ins;
				done_q <= !ld_entry.ins;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'(kbp_pkg::HASH_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (take) begin
				done_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kbp_back.sv =====
// kbp_back: Bloom bit memory, clearing sweep, six read-modify-writes per word pair, result register.
// Depends on kbp_pkg.
`default_nettype none
module kbp_back #(
	parameter int ADDR_BITS = 23
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  avail,
	output logic                       take,
	input  wire kbp_pkg::entry_t       entry,
	input  wire logic [kbp_pkg::NUM_OPS-1:0][ADDR_BITS-1:0] idx,
	output logic                       clearing,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output kbp_pkg::result_t           result
);

	localparam int ROW_BITS = ADDR_BITS - kbp_pkg::ROW_LSB;

	logic [63:0] mem [2**ROW_BITS];
	logic [63:0] rdata_q;

	logic            clear_q, active_q, out_v_q;
	logic [ROW_BITS-1:0] clr_cnt_q;
	kbp_pkg::entry_t ent_q;
	logic [kbp_pkg::NUM_OPS-1:0][ADDR_BITS-1:0] idx_q;
	logic [2:0]      iss_q;
	logic            p1_v_q;
	logic [ROW_BITS-1:0] p1_row_q;
	logic [5:0]      p1_bit_q;
	logic [2:0]      p1_op_q;
	logic            wr_v_q;
	logic [ROW_BITS-1:0] wr_row_q;
	logic [63:0]     wr_data_q;
	logic [kbp_pkg::NUM_OPS-1:0] hit_q;
	kbp_pkg::result_t out_q;

	logic            issue, fin, out_free, mem_we;
	logic [ADDR_BITS-1:0] iss_idx;
	logic [ROW_BITS-1:0]  rd_row, mem_row;
	logic [63:0]     fwd_data, new_data, mem_wdata;

	assign clearing     = clear_q;
	assign take         = avail && !active_q && !clear_q;
	assign issue        = active_q && (iss_q < 3'(kbp_pkg::NUM_OPS));
	assign iss_idx      = idx_q[iss_q];
	assign rd_row       = iss_idx[ADDR_BITS-1:kbp_pkg::ROW_LSB];
	assign fin          = active_q && (iss_q == 3'(kbp_pkg::NUM_OPS)) && !p1_v_q;
	assign out_free     = !out_v_q || !result_stall;
	assign result_valid = out_v_q;
	assign result       = out_q;

	// row written last cycle has not reached the registered read yet
	assign fwd_data  = (wr_v_q && wr_row_q == p1_row_q) ? wr_data_q : rdata_q;
	assign new_data  = fwd_data | (64'd1 << p1_bit_q);
	assign mem_we    = clear_q || p1_v_q;
	assign mem_row   = clear_q ? clr_cnt_q : p1_row_q;
	assign mem_wdata = clear_q ? 64'd0 : new_data;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_row] <= mem_wdata;
		rdata_q <= mem[rd_row];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_q <= entry;
			idx_q <= idx;
		end
		if (issue) begin
			p1_row_q <= rd_row;
			p1_bit_q <= iss_idx[kbp_pkg::ROW_LSB-1:0];
			p1_op_q  <= iss_q;
		end
		if (p1_v_q) begin
			wr_row_q  <= p1_row_q;
			wr_data_q <= new_data;
		end
		if (fin && out_free) begin
			out_q.inserted       <= ent_q.ins;
			out_q.forward_word   <= ent_q.fwd;
			out_q.forward_repeat <= ent_q.ins && (&hit_q[2:0]);
			out_q.reverse_word   <= ent_q.rev;
			out_q.reverse_repeat <= ent_q.ins && (&hit_q[5:3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q   <= 1'b1;
			clr_cnt_q <= '0;
			active_q  <= 1'b0;
			iss_q     <= '0;
			p1_v_q    <= 1'b0;
			wr_v_q    <= 1'b0;
			hit_q     <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (clear_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (&clr_cnt_q)
					clear_q <= 1'b0;
			end
			p1_v_q <= issue;
			wr_v_q <= p1_v_q;
			if (take) begin
				active_q <= 1'b1;
				iss_q    <= entry.ins ? 3'd0 : 3'(kbp_pkg::NUM_OPS);
				hit_q    <= '0;
			end else begin
				if (issue)
					iss_q <= iss_q + 3'd1;
				if (p1_v_q)
					hit_q[p1_op_q] <= fwd_data[p1_bit_q];
				if (fin && out_free)
					active_q <= 1'b0;
			end
			if (fin && out_free)
				out_v_q <= 1'b1;
			else if (!result_stall)
				out_v_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kmer_bloom_prefilter.sv =====
// kmer_bloom_prefilter: top level, configuration registers and the front/queue/hash/back chain.
// Depends on kbp_pkg, kbp_front, kbp_queue, kbp_hash, kbp_back.
//
//  channel   | direction | handshake               | word
//  item      | in        | item_valid/item_stall   | kbp_pkg::item_t
//  result    | out       | result_valid/result_stall | kbp_pkg::result_t
//  config    | in/out    | APB psel/penable/pready | 32-bit registers at 4*i
//
// The pace of a base that inserts is set by the eight-step hash sequencer; the six bit
// read-modify-writes run alongside the hashing of the next word.
// A base that inserts nothing skips both the hash steps and the read-modify-writes.
// After reset the Bloom memory is swept clear, one 64-bit row a cycle, across all
// 2**(BLOOM_ADDR_BITS-6) rows (131072 at the default); items stall meanwhile.
// A stalled result holds in the output register; the queue keeps the front going.
`default_nettype none
module kmer_bloom_prefilter #(
	parameter int BLOOM_ADDR_BITS = 23
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire kbp_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output kbp_pkg::result_t      result,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [kbp_pkg::APB_ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [4:0] kmer_q, log2_q;
	logic [7:0] minq_q, defq_q;
	logic [4:0] kc, lb;
	logic [5:0] kp1;
	logic [6:0] wbits;
	kbp_pkg::cfg_t cfg;
	kbp_pkg::reg_idx_t ridx;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign ridx   = kbp_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_q <= 5'd23;
			minq_q <= 8'd17;
			defq_q <= 8'd20;
			log2_q <= 5'd23;
		end else if (wr_en) begin
			unique case (ridx)
				kbp_pkg::REG_KMER_LENGTH:     kmer_q <= pwdata[4:0];
				kbp_pkg::REG_MIN_QUALITY:     minq_q <= pwdata[7:0];
				kbp_pkg::REG_DEFAULT_QUALITY: defq_q <= pwdata[7:0];
				kbp_pkg::REG_BLOOM_LOG2:      log2_q <= pwdata[4:0];
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			kbp_pkg::REG_KMER_LENGTH:     prdata = {27'd0, kmer_q};
			kbp_pkg::REG_MIN_QUALITY:     prdata = {24'd0, minq_q};
			kbp_pkg::REG_DEFAULT_QUALITY: prdata = {24'd0, defq_q};
			kbp_pkg::REG_BLOOM_LOG2:      prdata = {27'd0, log2_q};
		endcase
	end

	always_comb begin
		kc        = (kmer_q > 5'(kbp_pkg::MAX_K)) ? 5'(kbp_pkg::MAX_K) : kmer_q;
		lb        = (log2_q > 5'(BLOOM_ADDR_BITS)) ? 5'(BLOOM_ADDR_BITS) : log2_q;
		kp1       = {1'b0, kc} + 6'd1;
		wbits     = {kp1, 1'b0};
		cfg.k     = kc;
		cfg.wmask = ~({64{1'b1}} << wbits);
		cfg.amask = ~({64{1'b1}} << lb);
		cfg.min_q = minq_q;
		cfg.def_q = defq_q;
	end

	logic            push, q_full, q_empty, q_pop, clearing;
	logic            h_ready, h_done, h_take;
	kbp_pkg::entry_t f_entry, q_entry, h_entry;
	logic [kbp_pkg::NUM_OPS-1:0][BLOOM_ADDR_BITS-1:0] h_idx;

	assign q_pop = h_ready && !q_empty;

	kbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg        (cfg),
		.hold       (q_full || clearing),
		.push       (push),
		.entry      (f_entry)
	);

	kbp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (f_entry),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_entry),
		.empty  (q_empty)
	);

	kbp_hash #(.ADDR_BITS(BLOOM_ADDR_BITS)) u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (q_pop),
		.ld_entry (q_entry),
		.cfg      (cfg),
		.ready    (h_ready),
		.done     (h_done),
		.take     (h_take),
		.entry    (h_entry),
		.idx      (h_idx)
	);

	kbp_back #(.ADDR_BITS(BLOOM_ADDR_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.avail        (h_done),
		.take         (h_take),
		.entry        (h_entry),
		.idx          (h_idx),
		.clearing     (clearing),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

// ===== rtl/kbp_checker.sv =====
// kbp_checker: port-level assertions for kmer_bloom_prefilter, bound to the top level.
// Depends on kbp_pkg and kmer_bloom_prefilter.
`default_nettype none
module kbp_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire kbp_pkg::result_t result,
	input wire logic             item_stall,
	input wire logic             pready
);

	// a word that was not inserted cannot report a repeat
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.inserted |-> !result.forward_repeat && !result.reverse_repeat)
		else $error("repeat flagged on a word that was not inserted");

	// an offered result word carries no unknown bits
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !$isunknown(result))
		else $error("unknown bits in offered result word");

	a_stall_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({item_stall, result_valid}))
		else $error("unknown handshake level");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind kmer_bloom_prefilter kbp_checker u_kbp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result),
	.item_stall   (item_stall),
	.pready       (pready)
);
`default_nettype wire

// ===== bench/kmer_bloom_prefilter_tb.sv =====
// kmer_bloom_prefilter_tb: self-checking bench for the k-mer Bloom prefilter.
// Depends on kbp_pkg and kmer_bloom_prefilter; a scoreboard class predicts each result word.
`timescale 1ns / 100ps
`default_nettype none

class bloom_scoreboard;
	localparam int ADDR_BITS = 23;

	bit bloom_bits[];
	logic [63:0] fwd_word, rev_word;
	int run_len;
	logic [4:0] kmer_len, bloom_log2;
	logic [7:0] min_q, def_q;
	kbp_pkg::result_t expected_results[$];
	int errors;
	int inserts, repeats;

	function new();
		bloom_bits = new[1 << ADDR_BITS];
		fwd_word = 0;
		rev_word = 0;
		run_len = 0;
		kmer_len = 23;
		min_q = 17;
		def_q = 20;
		bloom_log2 = 23;
		errors = 0;
		inserts = 0;
		repeats = 0;
	endfunction

	function void set_reg(kbp_pkg::reg_idx_t idx, logic [31:0] val);
		case (idx)
			kbp_pkg::REG_KMER_LENGTH:     kmer_len = val[4:0];
			kbp_pkg::REG_MIN_QUALITY:     min_q = val[7:0];
			kbp_pkg::REG_DEFAULT_QUALITY: def_q = val[7:0];
			kbp_pkg::REG_BLOOM_LOG2:      bloom_log2 = val[4:0];
		endcase
	endfunction

	function logic [63:0] hash_a(logic [63:0] v, logic [63:0] m);
		v = (v + ~(v << 32)) & m;
		v = (v ^ (v >> 22)) & m;
		v = (v + (v << 13)) & m;
		v = (v ^ (v >> 24)) & m;
		v = (v + ~(v << 27)) & m;
		v = (v ^ (v >> 31)) & m;
		return v;
	endfunction

	function logic [63:0] hash_b(logic [63:0] v);
		v = (~v) + (v << 21);
		v = v ^ (v >> 24);
		v = (v + (v << 3)) + (v << 8);
		v = v ^ (v >> 14);
		v = (v + (v << 2)) + (v << 4);
		v = v ^ (v >> 28);
		v = v + (v << 31);
		return v;
	endfunction

	function logic [63:0] hash_c(logic [63:0] v, logic [63:0] m);
		logic [63:0] t;
		t = (v ^ (v >> 31)) & m;
		v = (v ^ (t >> 31)) & m;
		t = (v - (~v << 27)) & m;
		v = (v - (~t << 27) + 64'd1) & m;
		t = (v ^ (v >> 24)) & m;
		v = (v ^ (t >> 24)) & m;
		t = (v - (v << 13)) & m;
		t = (v - (t << 13)) & m;
		t = (v - (t << 13)) & m;
		v = (v - (t << 13)) & m;
		t = (v ^ (v >> 22)) & m;
		t = (v ^ (t >> 22)) & m;
		v = (v ^ (t >> 22)) & m;
		t = (v - (~v << 32)) & m;
		v = (v - (~t << 32) + 64'd1) & m;
		return v;
	endfunction

	function int test_set(logic [63:0] idx);
		int old;
		old = bloom_bits[idx[ADDR_BITS-1:0]];
		bloom_bits[idx[ADDR_BITS-1:0]] = 1'b1;
		return old;
	endfunction

	function logic insert_word(logic [63:0] w, logic [63:0] wm, logic [63:0] am);
		int hits;
		hits = test_set(hash_a(w, wm) & am);
		hits += test_set(hash_b(w) & am);
		hits += test_set(hash_c(w, wm) & am);
		return hits == 3;
	endfunction

	function void note_base(kbp_pkg::item_t it);
		int k, lb, code;
		logic [63:0] wm, am;
		logic [7:0] q;
		kbp_pkg::result_t r;
		k = kmer_len > 30 ? 30 : kmer_len;
		lb = bloom_log2 > ADDR_BITS ? ADDR_BITS : bloom_log2;
		wm = (64'd1 << ((k + 1) * 2)) - 64'd1;
		am = (64'd1 << lb) - 64'd1;
		r = '0;
		if (it.first_of_read) begin
			fwd_word = 0;
			rev_word = 0;
			run_len = 0;
		end
		case (it.base_char)
			"A", "a": code = 0;
			"C", "c": code = 1;
			"G", "g": code = 2;
			"T", "t": code = 3;
			default:  code = 4;
		endcase
		q = it.quality_present ? it.qual_char - kbp_pkg::QUAL_OFFSET : def_q;
		if (code < 4) begin
			fwd_word = ((fwd_word << 2) | 64'(code)) & wm;
			rev_word = (((rev_word & wm) >> 2) | (64'(3 - code) << (k * 2))) & wm;
			run_len = run_len + 1 > k + 1 ? k + 1 : run_len + 1;
			if (run_len >= k + 1 && q >= min_q) begin
				r.inserted = 1'b1;
				r.forward_repeat = insert_word(fwd_word, wm, am);
				r.reverse_repeat = insert_word(rev_word, wm, am);
				inserts++;
				repeats += r.forward_repeat + r.reverse_repeat;
			end
		end else begin
			run_len = 0;
		end
		r.forward_word = fwd_word[61:0];
		r.reverse_word = rev_word[61:0];
		expected_results.push_back(r);
	endfunction

	function void report(string name, logic [63:0] e, logic [63:0] g);
		if (e !== g) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, e, g);
			errors++;
		end
	endfunction

	function void check_result(kbp_pkg::result_t got);
		kbp_pkg::result_t e;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result word, expected none, actual %h", $realtime, got);
			errors++;
			return;
		end
		e = expected_results.pop_front();
		report("inserted", 64'(e.inserted), 64'(got.inserted));
		report("forward_word", 64'(e.forward_word), 64'(got.forward_word));
		report("forward_repeat", 64'(e.forward_repeat), 64'(got.forward_repeat));
		report("reverse_word", 64'(e.reverse_word), 64'(got.reverse_word));
		report("reverse_repeat", 64'(e.reverse_repeat), 64'(got.reverse_repeat));
	endfunction
endclass

module kmer_bloom_prefilter_tb;
	localparam int WATCHDOG_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	kbp_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	kbp_pkg::result_t result;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [kbp_pkg::APB_ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	bloom_scoreboard sb;
	int send_idle_pct = 0;
	int stall_pct = 0;
	logic hold_off = 1'b0;
	int idle_cycles = 0;
	int read_left = 0;
	int items_sent = 0;

	kmer_bloom_prefilter u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// receiver: take a word when it was offered and not stalled, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
		result_stall <= hold_off || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $realtime);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic reg_write(kbp_pkg::reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_results.size() != 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic configure(int k, int mq, int dq, int lb);
		drain();
		reg_write(kbp_pkg::REG_KMER_LENGTH, k);
		reg_write(kbp_pkg::REG_MIN_QUALITY, mq);
		reg_write(kbp_pkg::REG_DEFAULT_QUALITY, dq);
		reg_write(kbp_pkg::REG_BLOOM_LOG2, lb);
	endtask

	task automatic send(kbp_pkg::item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		sb.note_base(it);
		items_sent++;
	endtask

	task automatic send_base(byte ch, byte qc, bit qp, bit first);
		kbp_pkg::item_t it;
		it.base_char = ch;
		it.qual_char = qc;
		it.quality_present = qp;
		it.first_of_read = first;
		send(it);
	endtask

	// mostly well-formed reads of random length; some noise bytes and raw qualities
	task automatic send_random();
		kbp_pkg::item_t it;
		byte acgt[8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};
		it.first_of_read = 1'b0;
		if (read_left == 0) begin
			it.first_of_read = 1'b1;
			read_left = $urandom_range(40, 5);
		end
		read_left--;
		it.base_char = ($urandom_range(99) < 7) ? 8'($urandom) : acgt[$urandom_range(7)];
		it.qual_char = ($urandom_range(99) < 10) ? 8'($urandom) : 8'($urandom_range(83, 33));
		it.quality_present = $urandom_range(99) < 85;
		send(it);
	endtask

	task automatic run_phase(int n, int sp, int rp);
		send_idle_pct = sp;
		stall_pct = rp;
		repeat (n) send_random();
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		configure(2, 17, 20, 23);

		// directed: every base in both cases, a repeated word, breaks, quality edges
		send_base("A", "I", 1, 1);
		send_base("c", "I", 1, 0);
		send_base("G", "I", 1, 0);
		send_base("t", "I", 1, 0);
		send_base("a", "I", 1, 0);
		send_base("C", "I", 1, 0);
		send_base("g", "I", 1, 0);
		send_base("T", "I", 1, 0);
		send_base("A", "I", 1, 0);
		send_base("N", "I", 1, 0);
		send_base("C", "I", 1, 0);
		send_base("G", "I", 1, 0);
		send_base("T", 8'd33, 1, 0);
		send_base("A", 8'd32, 1, 0);
		send_base("C", 8'd0, 1, 0);
		send_base("G", 8'd255, 0, 0);
		send_base(8'hff, 8'hff, 1, 0);
		send_base(8'h00, 8'h00, 0, 0);
		send_base("T", "I", 1, 1);
		send_base("T", "I", 1, 0);
		send_base("T", "I", 1, 0);
		send_base("T", "I", 1, 0);

		configure(23, 17, 20, 23);
		run_phase(110, 0, 0);
		configure(1, 0, 0, 1);
		run_phase(110, 78, 0);
		configure(30, 255, 255, 23);
		run_phase(100, 0, 78);
		configure(3, 10, 5, 8);
		run_phase(160, 18, 18);
		// long receiver hold-off while items keep coming, so the input backs up
		hold_off <= 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off <= 1'b0;
			end
			run_phase(40, 0, 0);
		join
		configure(31, 30, 40, 31);
		run_phase(100, 18, 18);
		configure(0, 0, 255, 0);
		run_phase(100, 78, 0);
		configure(5, 17, 20, 12);
		run_phase(110, 0, 78);
		drain();

		$display("%0d bases sent over 8 register settings; %0d insertions, %0d repeat bits seen",
			items_sent, sb.inserts, sb.repeats);
		if (sb.expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $realtime,
				sb.expected_results.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/kbp_pkg.sv
rtl/kbp_front.sv
rtl/kbp_queue.sv
rtl/kbp_hash.sv
rtl/kbp_back.sv
rtl/kmer_bloom_prefilter.sv
rtl/kbp_checker.sv
bench/kmer_bloom_prefilter_tb.sv
